>>> rtl/core/ppfd_pkg.sv
// ppfd_pkg: types, constants and the command table for the pulse-pair frame decoder.
// No dependencies; used by ppfd_classify and pulse_pair_frame_decoder.
package ppfd_pkg;

  localparam int FRAME_SYMS   = 25;
  localparam int CMD_SYMS     = 10;
  localparam int CMD_COUNT    = 13;
  localparam int MAX_START    = 2;
  localparam int FRAME_PULSES = 2 * FRAME_SYMS;

  localparam logic [3:0] NO_CMD = 4'd13;

  // register reset values
  localparam logic [7:0]  TOLERANCE_RST        = 8'd150;
  localparam logic [15:0] SHORT_ON_TARGET_RST  = 16'd400;
  localparam logic [15:0] LONG_ON_TARGET_RST   = 16'd850;
  localparam logic [15:0] SHORT_OFF_TARGET_RST = 16'd500;
  localparam logic [15:0] LONG_OFF_TARGET_RST  = 16'd950;
  localparam logic [15:0] REST_MINIMUM_RST     = 16'd8000;
  localparam logic [15:0] REST_MAXIMUM_RST     = 16'd12000;
  localparam logic [15:0] LEAD_THRESHOLD_RST   = 16'd5000;

  typedef enum logic [2:0] {
    SYM_SS = 3'd0,
    SYM_SL = 3'd1,
    SYM_LL = 3'd2,
    SYM_LS = 3'd3,
    SYM_SR = 3'd4
  } sym_t;

  typedef enum logic [2:0] {
    REG_TOLERANCE        = 3'd0,
    REG_SHORT_ON_TARGET  = 3'd1,
    REG_LONG_ON_TARGET   = 3'd2,
    REG_SHORT_OFF_TARGET = 3'd3,
    REG_LONG_OFF_TARGET  = 3'd4,
    REG_REST_MINIMUM     = 3'd5,
    REG_REST_MAXIMUM     = 3'd6,
    REG_LEAD_THRESHOLD   = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAD_RD,
    ST_LEAD_CHK,
    ST_TRY,
    ST_ON,
    ST_OFF,
    ST_CLS,
    ST_MATCH,
    ST_EMIT
  } state_t;

  // timing windows, lower edges already clamped at zero
  typedef struct packed {
    logic [15:0] s_on_lo;
    logic [16:0] s_on_hi;
    logic [15:0] l_on_lo;
    logic [16:0] l_on_hi;
    logic [15:0] s_off_lo;
    logic [16:0] s_off_hi;
    logic [15:0] l_off_lo;
    logic [16:0] l_off_hi;
    logic [15:0] rest_min;
    logic [15:0] rest_max;
  } bounds_t;

  typedef struct packed {
    logic hit;
    sym_t code;
  } class_t;

  // command table: first symbol of the tail in the top three bits
  localparam logic [3*CMD_SYMS-1:0] CMD_TABLE [CMD_COUNT] = '{
    {3'd1, 3'd1, 3'd0, 3'd3, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd1, 3'd0, 3'd3, 3'd3, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd2, 3'd0, 3'd3, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd1, 3'd1, 3'd0, 3'd3, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd3, 3'd2, 3'd0, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd1, 3'd0, 3'd2, 3'd0, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd3, 3'd3, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd4},
    {3'd2, 3'd0, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0, 3'd2, 3'd4},
    {3'd1, 3'd1, 3'd1, 3'd0, 3'd3, 3'd3, 3'd2, 3'd4, 3'd1, 3'd1}
  };

  // first matching table entry, NO_CMD if none
  function automatic logic [3:0] cmd_lookup(logic [3*CMD_SYMS-1:0] tail);
    logic [3:0] cmd;
    cmd = NO_CMD;
    for (int c = CMD_COUNT - 1; c >= 0; c--) begin
      if (tail == CMD_TABLE[c]) cmd = 4'(c);
    end
    return cmd;
  endfunction

  function automatic logic [15:0] win_lo(logic [15:0] target, logic [7:0] tol);
    return (target >= 16'(tol)) ? target - 16'(tol) : 16'd0;
  endfunction

  function automatic logic [16:0] win_hi(logic [15:0] target, logic [7:0] tol);
    return 17'(target) + 17'(tol);
  endfunction

endpackage

>>> rtl/core/ppfd_classify.sv
// ppfd_classify: sorts one on/off pair into a symbol code against the window bounds.
// Depends on ppfd_pkg (bounds_t, class_t, sym_t).
module ppfd_classify (
  input  ppfd_pkg::bounds_t bounds,
  input  logic [15:0]       on_dur,
  input  logic [15:0]       off_dur,
  output ppfd_pkg::class_t  result
);

  logic s_on, l_on, s_off, l_off, rest;

  assign s_on  = (on_dur  >= bounds.s_on_lo)  && (17'(on_dur)  <= bounds.s_on_hi);
  assign l_on  = (on_dur  >= bounds.l_on_lo)  && (17'(on_dur)  <= bounds.l_on_hi);
  assign s_off = (off_dur >= bounds.s_off_lo) && (17'(off_dur) <= bounds.s_off_hi);
  assign l_off = (off_dur >= bounds.l_off_lo) && (17'(off_dur) <= bounds.l_off_hi);
  assign rest  = (off_dur >= bounds.rest_min) && (off_dur <= bounds.rest_max);

  // priority follows the symbol order SS, SL, LL, LS, SR
  always_comb begin
    result.hit  = 1'b1;
    result.code = ppfd_pkg::SYM_SS;
    if (s_on && s_off) begin
      result.code = ppfd_pkg::SYM_SS;
    end else if (s_on && l_off) begin
      result.code = ppfd_pkg::SYM_SL;
    end else if (l_on && l_off) begin
      result.code = ppfd_pkg::SYM_LL;
    end else if (l_on && s_off) begin
      result.code = ppfd_pkg::SYM_LS;
    end else if (s_on && rest) begin
      result.code = ppfd_pkg::SYM_SR;
    end else begin
      result.hit = 1'b0;
    end
  end

endmodule

>>> rtl/core/pulse_pair_frame_decoder.sv
// pulse_pair_frame_decoder: top level; capture store, decode sequencer, output register.
// Depends on ppfd_pkg and ppfd_classify.
//
// Use:
//   Slave side (s_*) takes one pulse or gap duration per word, on and off durations
//   alternating; s_tlast marks the word that closes the capture. Words up to
//   CAPTURE_DEPTH are kept, later ones are dropped.
//   After the closing word the block walks the store: one read for the lead
//   check, then per on/off pair a read of on, a read of off and a classify,
//   over up to three start offsets, then the command lookup. s_tready is low
//   meanwhile.
//   Master side (m_*) then gives 25 symbol words (m_tuser = found = 1), or one
//   not-found word (found = 0, command 13); m_tlast flags the final word. One word
//   a cycle leaves while m_tready is high; a low m_tready holds the output register
//   and stalls the walk of words, nothing is lost. The last output word may still
//   wait while the next capture is already being taken.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are expected only while
//   the block is idle.
//   Reset (rst, synchronous) restores the register defaults, empties the capture
//   and drops any pending output. The store itself is not cleared.
module pulse_pair_frame_decoder #(
  parameter int CAPTURE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] duration
  input  logic        s_tlast,
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] symbol, [7:3] position, [11:8] command, [15:12] zero
  output logic [0:0]  m_tuser,   // [0] found
  output logic        m_tlast
);

  localparam int IDX_W = $clog2(CAPTURE_DEPTH);
  localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);
  localparam int SYM_N = ppfd_pkg::FRAME_SYMS;
  localparam int TAIL0 = ppfd_pkg::FRAME_SYMS - ppfd_pkg::CMD_SYMS;

  // configuration registers
  logic [7:0]  tolerance;
  logic [15:0] short_on_target, long_on_target, short_off_target, long_off_target;
  logic [15:0] rest_minimum, rest_maximum, lead_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance        <= ppfd_pkg::TOLERANCE_RST;
      short_on_target  <= ppfd_pkg::SHORT_ON_TARGET_RST;
      long_on_target   <= ppfd_pkg::LONG_ON_TARGET_RST;
      short_off_target <= ppfd_pkg::SHORT_OFF_TARGET_RST;
      long_off_target  <= ppfd_pkg::LONG_OFF_TARGET_RST;
      rest_minimum     <= ppfd_pkg::REST_MINIMUM_RST;
      rest_maximum     <= ppfd_pkg::REST_MAXIMUM_RST;
      lead_threshold   <= ppfd_pkg::LEAD_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (ppfd_pkg::reg_index_t'(cfg_index))
        ppfd_pkg::REG_TOLERANCE:        tolerance        <= cfg_data[7:0];
        ppfd_pkg::REG_SHORT_ON_TARGET:  short_on_target  <= cfg_data;
        ppfd_pkg::REG_LONG_ON_TARGET:   long_on_target   <= cfg_data;
        ppfd_pkg::REG_SHORT_OFF_TARGET: short_off_target <= cfg_data;
        ppfd_pkg::REG_LONG_OFF_TARGET:  long_off_target  <= cfg_data;
        ppfd_pkg::REG_REST_MINIMUM:     rest_minimum     <= cfg_data;
        ppfd_pkg::REG_REST_MAXIMUM:     rest_maximum     <= cfg_data;
        ppfd_pkg::REG_LEAD_THRESHOLD:   lead_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // window edges, refreshed every cycle; settled long before a decode starts
  ppfd_pkg::bounds_t bounds;

  always_ff @(posedge clk) begin
    bounds.s_on_lo  <= ppfd_pkg::win_lo(short_on_target, tolerance);
    bounds.s_on_hi  <= ppfd_pkg::win_hi(short_on_target, tolerance);
    bounds.l_on_lo  <= ppfd_pkg::win_lo(long_on_target, tolerance);
    bounds.l_on_hi  <= ppfd_pkg::win_hi(long_on_target, tolerance);
    bounds.s_off_lo <= ppfd_pkg::win_lo(short_off_target, tolerance);
    bounds.s_off_hi <= ppfd_pkg::win_hi(short_off_target, tolerance);
    bounds.l_off_lo <= ppfd_pkg::win_lo(long_off_target, tolerance);
    bounds.l_off_hi <= ppfd_pkg::win_hi(long_off_target, tolerance);
    bounds.rest_min <= rest_minimum;
    bounds.rest_max <= rest_maximum;
  end

  // sequencer
  ppfd_pkg::state_t state, state_next;

  logic [CNT_W-1:0] pulse_count;   // words held in the current capture
  logic [CNT_W-1:0] len;           // capture length frozen at the closing word
  logic [1:0]       start;         // current start offset
  logic [4:0]       pair;          // pair index within the frame
  logic [15:0]      on_val;
  logic [2:0]       syms [SYM_N];
  logic [3:0]       cmd;
  logic             found;
  logic [4:0]       pos;           // next output position

  // capture store, one write port and one registered read port
  logic [15:0]      pulse_store [CAPTURE_DEPTH];
  logic [15:0]      rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             in_acc, store_room;

  assign in_acc     = s_tvalid && s_tready;
  assign store_room = pulse_count < CNT_W'(CAPTURE_DEPTH);

  always_ff @(posedge clk) begin
    if (in_acc && store_room) pulse_store[pulse_count[IDX_W-1:0]] <= s_tdata;
    rdata <= pulse_store[rd_addr];
  end

  // address of the current on or off word; never beyond 51, inside any legal depth
  logic [5:0] pulse_addr;
  assign pulse_addr = 6'(start) + {pair, 1'b0} + ((state == ppfd_pkg::ST_OFF) ? 6'd1 : 6'd0);

  // a start offset is tried only if its 50 words lie inside the capture
  logic start_fits;
  assign start_fits = (start <= 2'(ppfd_pkg::MAX_START))
                   && (10'(start) + 10'(ppfd_pkg::FRAME_PULSES) <= 10'(len));

  ppfd_pkg::class_t cls;

  ppfd_classify u_classify (
    .bounds  (bounds),
    .on_dur  (on_val),
    .off_dur (rdata),
    .result  (cls)
  );

  // tail of the frame for the command lookup
  logic [3*ppfd_pkg::CMD_SYMS-1:0] tail;
  always_comb begin
    for (int j = 0; j < ppfd_pkg::CMD_SYMS; j++) begin
      tail[3*(ppfd_pkg::CMD_SYMS-1-j) +: 3] = syms[TAIL0 + j];
    end
  end

  logic out_load, last_word;
  assign out_load  = (state == ppfd_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  assign last_word = !found || (pos == 5'(SYM_N - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= ppfd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_addr    = IDX_W'(pulse_addr);
    unique case (state)
      ppfd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) state_next = ppfd_pkg::ST_LEAD_RD;
      end
      ppfd_pkg::ST_LEAD_RD: begin
        rd_addr    = '0;
        state_next = ppfd_pkg::ST_LEAD_CHK;
      end
      ppfd_pkg::ST_LEAD_CHK: state_next = ppfd_pkg::ST_TRY;
      ppfd_pkg::ST_TRY:      state_next = start_fits ? ppfd_pkg::ST_ON : ppfd_pkg::ST_EMIT;
      ppfd_pkg::ST_ON:       state_next = ppfd_pkg::ST_OFF;
      ppfd_pkg::ST_OFF:      state_next = ppfd_pkg::ST_CLS;
      ppfd_pkg::ST_CLS: begin
        if (!cls.hit)                       state_next = ppfd_pkg::ST_TRY;
        else if (pair == 5'(SYM_N - 1))     state_next = ppfd_pkg::ST_MATCH;
        else                                state_next = ppfd_pkg::ST_ON;
      end
      ppfd_pkg::ST_MATCH:    state_next = ppfd_pkg::ST_EMIT;
      ppfd_pkg::ST_EMIT: begin
        if (out_load && last_word) state_next = ppfd_pkg::ST_IDLE;
      end
      default:               state_next = ppfd_pkg::ST_IDLE;
    endcase
  end

  // capture count and frozen length
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
    end else if (in_acc) begin
      if (s_tlast)         pulse_count <= '0;
      else if (store_room) pulse_count <= pulse_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) len <= store_room ? pulse_count + 1'b1 : pulse_count;
  end

  // decode datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ppfd_pkg::ST_LEAD_CHK: begin
        start <= (rdata > lead_threshold) ? 2'd1 : 2'd0;
      end
      ppfd_pkg::ST_TRY: begin
        pair  <= '0;
        pos   <= '0;
        found <= 1'b0;
        cmd   <= ppfd_pkg::NO_CMD;
      end
      ppfd_pkg::ST_OFF: on_val <= rdata;
      ppfd_pkg::ST_CLS: begin
        if (cls.hit) begin
          syms[pair] <= cls.code;
          pair       <= pair + 1'b1;
        end else begin
          start <= start + 1'b1;
        end
      end
      ppfd_pkg::ST_MATCH: begin
        found <= 1'b1;
        cmd   <= ppfd_pkg::cmd_lookup(tail);
      end
      ppfd_pkg::ST_EMIT: begin
        if (out_load) pos <= pos + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'd0, cmd, found ? pos : 5'd0, found ? syms[pos] : 3'(ppfd_pkg::SYM_SS)};
      m_tuser <= found;
      m_tlast <= last_word;
    end
  end

endmodule
